/* sv/lei_pkg.sv */
// shared types, codes and helpers for the lorenz euler integrator
package lei_pkg;

    localparam int W_WORD = 32;
    localparam int W_GAIN = 31;
    localparam int W_OPND = 33;
    localparam int W_PROD = 2 * W_OPND;
    localparam int W_WIDE = W_PROD + 2;

    typedef logic signed [W_WIDE-1:0] t_wide;
    typedef logic signed [W_OPND-1:0] t_opnd;
    typedef logic signed [W_WORD-1:0] t_word;
    typedef logic [W_GAIN-1:0] t_gain;
    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_cfg_idx;
    typedef logic [3:0] t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    localparam t_cmd CMD_STEP = 2'd0;
    localparam t_cmd CMD_LOAD = 2'd1;

    localparam t_cfg_idx CFG_SIGMA = 2'd0;
    localparam t_cfg_idx CFG_RHO   = 2'd1;
    localparam t_cfg_idx CFG_BETA  = 2'd2;
    localparam t_cfg_idx CFG_DT    = 2'd3;

    // multiply schedule, one op issued per cycle
    localparam t_op OP_DX   = 4'd0;
    localparam t_op OP_DY   = 4'd1;
    localparam t_op OP_XY   = 4'd2;
    localparam t_op OP_DZ   = 4'd3;
    localparam t_op OP_NX   = 4'd4;
    localparam t_op OP_NY   = 4'd5;
    localparam t_op OP_NZ   = 4'd6;
    localparam t_op OP_SDT  = 4'd7;
    localparam t_op OP_RZDT = 4'd8;
    localparam t_op OP_XDT  = 4'd9;
    localparam t_op OP_YDT  = 4'd10;
    localparam t_op OP_BDT  = 4'd11;

    localparam t_wide MAX_WORD = t_wide'(64'sd2147483647);
    localparam t_wide MIN_WORD = t_wide'(-64'sd2147483648);

    function automatic t_word f_sat32(input t_wide v);
        t_word r;
        if (v > MAX_WORD) begin
            r = 32'sh7fffffff;
        end else if (v < MIN_WORD) begin
            r = 32'sh80000000;
        end else begin
            r = v[W_WORD-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/lei_mulq.sv */
// shared signed multiplier with registered product and round-to-nearest scaling
module lei_mulq #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 i_clk,
    input  lei_pkg::t_opnd       i_a,
    input  lei_pkg::t_opnd       i_b,
    output lei_pkg::t_wide       o_q
);
    import lei_pkg::*;

    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_PROD-1:0] w_biased;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // ties go up, arithmetic shift floors
    assign w_biased = r_prod + (W_PROD'(1) <<< (FRAC_BITS - 1));
    assign o_q = W_WIDE'(w_biased >>> FRAC_BITS);

endmodule

/* sv/lorenz_euler_integrator_top.sv */
// lorenz system forward-euler integrator with jacobian output
//
// input channel: i_valid / o_ready carry one word: i_cmd plus load_x/y/z.
// cmd step advances the state by one euler step, load replaces it, query
// (and the unused code) leaves it. every word yields one output word on
// o_valid / i_ready: the state after the word and eight jacobian entries.
// state and outputs are signed fixed point with FRAC_BITS fraction bits,
// gains and dt unsigned; overflow saturates. gains and dt come in on the
// write port (i_cfg_wen, i_cfg_idx, i_cfg_data); the user must see that they
// are written only while the block is idle, the block does not enforce it.
// one 33x33 multiplier is time shared under a small sequencer that issues
// one product per cycle, each written back in the cycle after its issue.
// step: 12 products, load or query: 5 products. o_valid rises once the
// last product has been written back. o_ready is high only while idle.
// a stalled output holds its word; nothing new is taken until it leaves.
// reset restores the default gains and the default starting state.
module lorenz_euler_integrator_top #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  lei_pkg::t_cfg_idx    i_cfg_idx,
    input  lei_pkg::t_gain       i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lei_pkg::t_cmd        i_cmd,
    input  lei_pkg::t_word       i_load_x,
    input  lei_pkg::t_word       i_load_y,
    input  lei_pkg::t_word       i_load_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lei_pkg::t_word       o_pos_x,
    output lei_pkg::t_word       o_pos_y,
    output lei_pkg::t_word       o_pos_z,
    output lei_pkg::t_word       o_jac_xx,
    output lei_pkg::t_word       o_jac_xy,
    output lei_pkg::t_word       o_jac_yx,
    output lei_pkg::t_word       o_jac_yy,
    output lei_pkg::t_word       o_jac_yz,
    output lei_pkg::t_word       o_jac_zx,
    output lei_pkg::t_word       o_jac_zy,
    output lei_pkg::t_word       o_jac_zz
);
    import lei_pkg::*;

    localparam longint RST_SIGMA = longint'(10) << FRAC_BITS;
    localparam longint RST_RHO   = longint'(28) << FRAC_BITS;
    localparam longint RST_BETA  = ((longint'(8) << FRAC_BITS) + 1) / 3;
    localparam longint RST_DT    = ((longint'(1) << FRAC_BITS) + 50) / 100;
    localparam longint RST_X     = ((longint'(102786) << FRAC_BITS) + 5000) / 10000;
    localparam longint RST_Y     = ((longint'(891428) << FRAC_BITS) + 50000) / 100000;
    localparam longint RST_Z     = ((longint'(308217) << FRAC_BITS) + 5000) / 10000;
    localparam t_wide  ONE_Q     = t_wide'(1) <<< FRAC_BITS;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_op    r_wb_op;
    logic   r_wb_vld;

    t_gain r_sigma, r_rho, r_beta, r_dt;
    t_word r_x, r_y, r_z;
    t_word r_dx, r_dy, r_dz;
    t_wide r_xy;
    t_word r_jxx, r_jxy, r_jyx, r_jyy, r_jyz, r_jzx, r_jzy, r_jzz;

    logic  w_in_acc, w_out_acc, w_issue;
    t_opnd w_a, w_b;
    t_wide w_q;
    t_wide w_x, w_y, w_z;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_x = W_WIDE'(r_x);
    assign w_y = W_WIDE'(r_y);
    assign w_z = W_WIDE'(r_z);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_RUN;
                    n_op    = (i_cmd == CMD_STEP) ? OP_DX : OP_SDT;
                end
            end
            ST_RUN: begin
                if (r_op == OP_BDT) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_op = r_op + 4'd1;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        w_issue = 1'b0;
        case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_RUN:   w_issue = 1'b1;
            ST_DONE:  o_valid = 1'b1;
            default:  o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_DX;
            r_wb_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_wb_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_op <= r_op;
    end

    // operand select for the shared multiplier
    always_comb begin
        w_a = W_OPND'(r_x);
        w_b = W_OPND'(r_y);
        case (r_op)
            OP_DX: begin
                w_a = t_opnd'({2'b00, r_sigma});
                w_b = W_OPND'(r_y) - W_OPND'(r_x);
            end
            OP_DY: begin
                w_a = W_OPND'(r_x);
                w_b = t_opnd'({2'b00, r_rho}) - W_OPND'(r_z);
            end
            OP_XY: begin
                w_a = W_OPND'(r_x);
                w_b = W_OPND'(r_y);
            end
            OP_DZ: begin
                w_a = t_opnd'({2'b00, r_beta});
                w_b = W_OPND'(r_z);
            end
            OP_NX: begin
                w_a = W_OPND'(r_dx);
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_NY: begin
                w_a = W_OPND'(r_dy);
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_NZ: begin
                w_a = W_OPND'(r_dz);
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_SDT: begin
                w_a = t_opnd'({2'b00, r_sigma});
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_RZDT: begin
                w_a = t_opnd'({2'b00, r_rho}) - W_OPND'(r_z);
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_XDT: begin
                w_a = W_OPND'(r_x);
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_YDT: begin
                w_a = W_OPND'(r_y);
                w_b = t_opnd'({2'b00, r_dt});
            end
            OP_BDT: begin
                w_a = t_opnd'({2'b00, r_beta});
                w_b = t_opnd'({2'b00, r_dt});
            end
            default: begin
                w_a = W_OPND'(r_x);
                w_b = W_OPND'(r_y);
            end
        endcase
    end

    lei_mulq #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mulq (
        .i_clk(i_clk),
        .i_a  (w_a),
        .i_b  (w_b),
        .o_q  (w_q)
    );

    // configuration and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= W_GAIN'(RST_SIGMA);
            r_rho   <= W_GAIN'(RST_RHO);
            r_beta  <= W_GAIN'(RST_BETA);
            r_dt    <= W_GAIN'(RST_DT);
            r_x     <= f_sat32(W_WIDE'(RST_X));
            r_y     <= f_sat32(W_WIDE'(RST_Y));
            r_z     <= f_sat32(W_WIDE'(RST_Z));
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_SIGMA: r_sigma <= i_cfg_data;
                    CFG_RHO:   r_rho   <= i_cfg_data;
                    CFG_BETA:  r_beta  <= i_cfg_data;
                    CFG_DT:    r_dt    <= i_cfg_data;
                    default:   r_dt    <= r_dt;
                endcase
            end
            if (w_in_acc && i_cmd == CMD_LOAD) begin
                r_x <= i_load_x;
                r_y <= i_load_y;
                r_z <= i_load_z;
            end else if (r_wb_vld) begin
                case (r_wb_op)
                    OP_NX:   r_x <= f_sat32(w_x + w_q);
                    OP_NY:   r_y <= f_sat32(w_y + w_q);
                    OP_NZ:   r_z <= f_sat32(w_z + w_q);
                    default: r_x <= r_x;
                endcase
            end
        end
    end

    // jac_yy from dt on acceptance, and writeback of the product issued last cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_jyy <= f_sat32(ONE_Q - t_wide'({1'b0, r_dt}));
        end
        if (r_wb_vld) begin
            case (r_wb_op)
                OP_DX: r_dx <= f_sat32(w_q);
                OP_DY: r_dy <= f_sat32(w_q - w_y);
                OP_XY: r_xy <= w_q;
                OP_DZ: r_dz <= f_sat32(r_xy - w_q);
                OP_SDT: begin
                    r_jxy <= f_sat32(w_q);
                    r_jxx <= f_sat32(ONE_Q - w_q);
                end
                OP_RZDT: r_jyx <= f_sat32(w_q);
                OP_XDT: begin
                    r_jzy <= f_sat32(w_q);
                    r_jyz <= f_sat32(-w_q);
                end
                OP_YDT: r_jzx <= f_sat32(w_q);
                OP_BDT: r_jzz <= f_sat32(ONE_Q - w_q);
                default: r_xy <= r_xy;
            endcase
        end
    end

    assign o_pos_x  = r_x;
    assign o_pos_y  = r_y;
    assign o_pos_z  = r_z;
    assign o_jac_xx = r_jxx;
    assign o_jac_xy = r_jxy;
    assign o_jac_yx = r_jyx;
    assign o_jac_yy = r_jyy;
    assign o_jac_yz = r_jyz;
    assign o_jac_zx = r_jzx;
    assign o_jac_zy = r_jzy;
    assign o_jac_zz = r_jzz;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output handshakes open together");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd == CMD_STEP) |=> (r_state == ST_RUN && r_op == OP_DX))
        else $error("step word did not start the schedule at the first product");

    a_wb_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> (r_state == ST_RUN || r_state == ST_FLUSH))
        else $error("writeback outside the run window");

    a_done_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |=> (o_valid && r_wb_op == OP_BDT))
        else $error("output raised without the last product written");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> o_ready)
        else $error("block not idle after its word was taken");

endmodule

/* test/lorenz_euler_integrator_top_tb.sv */
// self-checking testbench for the lorenz euler integrator: random handshakes, gain sweeps
`timescale 1ns / 1ps

module lorenz_euler_integrator_top_tb;
    import lei_pkg::*;

    localparam t_cmd CMD_QUERY = 2'd2;
    localparam t_cmd CMD_SPARE = 2'd3;

    localparam t_word WORD_TOP = 32'sh7fffffff;
    localparam t_word WORD_BOT = 32'sh80000000;
    localparam t_gain GAIN_TOP = 31'h7fffffff;
    localparam t_gain GAIN_ZERO = 31'h0;

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int REPORT_LIMIT    = 10;

    typedef logic signed [79:0] t_acc;
    // pos_x, pos_y, pos_z, jac_xx, jac_xy, jac_yx, jac_yy, jac_yz, jac_zx, jac_zy, jac_zz
    typedef logic [0:10][31:0] t_outrec;

    class lorenz_tracker;
        localparam int FRAC = 24;
        localparam t_acc ONE_Q = t_acc'(1) <<< FRAC;
        localparam t_acc HALF_LSB = t_acc'(1) <<< (FRAC - 1);
        localparam t_acc ACC_TOP = t_acc'(32'sh7fffffff);
        localparam t_acc ACC_BOT = t_acc'(32'sh80000000);

        t_acc sigma, rho, beta, dt;
        t_acc px, py, pz;
        t_outrec expected_reports[$];
        string field_names [11] = '{"pos_x", "pos_y", "pos_z", "jac_xx", "jac_xy",
                                    "jac_yx", "jac_yy", "jac_yz", "jac_zx", "jac_zy",
                                    "jac_zz"};
        int n_step, n_load, n_query, n_spare;
        int n_seen, n_bad;

        function new();
            sigma = t_acc'(167772160);
            rho   = t_acc'(469762048);
            beta  = t_acc'(44739243);
            dt    = t_acc'(167772);
            px    = t_acc'(172446292);
            py    = t_acc'(149556801);
            pz    = t_acc'(517102318);
        endfunction

        function t_acc clamp32(t_acc v);
            if (v > ACC_TOP) begin
                return ACC_TOP;
            end
            if (v < ACC_BOT) begin
                return ACC_BOT;
            end
            return v;
        endfunction

        function t_word to_word(t_acc v);
            return t_word'(clamp32(v));
        endfunction

        // exact product, rounded to nearest with ties toward plus infinity
        function t_acc fx_mul(t_acc a, t_acc b);
            return (a * b + HALF_LSB) >>> FRAC;
        endfunction

        function void set_gain(t_cfg_idx idx, t_gain v);
            case (idx)
                CFG_SIGMA: sigma = t_acc'(v);
                CFG_RHO:   rho = t_acc'(v);
                CFG_BETA:  beta = t_acc'(v);
                CFG_DT:    dt = t_acc'(v);
                default: ;
            endcase
        endfunction

        function t_outrec state_report();
            t_outrec r;
            r[0]  = to_word(px);
            r[1]  = to_word(py);
            r[2]  = to_word(pz);
            r[3]  = to_word(ONE_Q - fx_mul(sigma, dt));
            r[4]  = to_word(fx_mul(sigma, dt));
            r[5]  = to_word(fx_mul(rho - pz, dt));
            r[6]  = to_word(ONE_Q - dt);
            r[7]  = to_word(-fx_mul(px, dt));
            r[8]  = to_word(fx_mul(py, dt));
            r[9]  = to_word(fx_mul(px, dt));
            r[10] = to_word(ONE_Q - fx_mul(beta, dt));
            return r;
        endfunction

        function void note_command(t_cmd cmd, t_word lx, t_word ly, t_word lz);
            t_acc dx, dy, dz;
            case (cmd)
                CMD_STEP: begin
                    // all three derivatives from the old state first
                    dx = clamp32(fx_mul(sigma, py - px));
                    dy = clamp32(fx_mul(px, rho - pz) - py);
                    dz = clamp32(fx_mul(px, py) - fx_mul(beta, pz));
                    px = clamp32(px + fx_mul(dx, dt));
                    py = clamp32(py + fx_mul(dy, dt));
                    pz = clamp32(pz + fx_mul(dz, dt));
                    n_step++;
                end
                CMD_LOAD: begin
                    px = t_acc'(lx);
                    py = t_acc'(ly);
                    pz = t_acc'(lz);
                    n_load++;
                end
                CMD_QUERY: n_query++;
                default: n_spare++;
            endcase
            expected_reports.push_back(state_report());
        endfunction

        function void check_output(t_outrec got);
            t_outrec want;
            n_seen++;
            if (expected_reports.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_LIMIT) begin
                    $display("output word %0d arrived with nothing pending", n_seen);
                end
                return;
            end
            want = expected_reports.pop_front();
            for (int f = 0; f < 11; f++) begin
                if (got[f] !== want[f]) begin
                    n_bad++;
                    if (n_bad <= REPORT_LIMIT) begin
                        $display("output word %0d %s: expected %0d (%08h), got %0d (%08h)",
                                 n_seen, field_names[f], $signed(want[f]), want[f],
                                 $signed(got[f]), got[f]);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_wen = 1'b0;
    t_cfg_idx  i_cfg_idx = CFG_SIGMA;
    t_gain     i_cfg_data = GAIN_ZERO;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_cmd      i_cmd = CMD_QUERY;
    t_word     i_load_x = '0;
    t_word     i_load_y = '0;
    t_word     i_load_z = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_word     o_pos_x, o_pos_y, o_pos_z;
    t_word     o_jac_xx, o_jac_xy, o_jac_yx, o_jac_yy;
    t_word     o_jac_yz, o_jac_zx, o_jac_zy, o_jac_zz;

    lorenz_tracker tracker = new();
    bit  no_gaps = 1'b0;
    int  rx_hold = 0;
    int  quiet_cycles = 0;
    int  n_settings = 1;

    lorenz_euler_integrator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_load_x   (i_load_x),
        .i_load_y   (i_load_y),
        .i_load_z   (i_load_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_pos_z    (o_pos_z),
        .o_jac_xx   (o_jac_xx),
        .o_jac_xy   (o_jac_xy),
        .o_jac_yx   (o_jac_yx),
        .o_jac_yy   (o_jac_yy),
        .o_jac_yz   (o_jac_yz),
        .o_jac_zx   (o_jac_zx),
        .o_jac_zy   (o_jac_zy),
        .o_jac_zz   (o_jac_zz)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (no_gaps || sel < 60) begin
            return 0;
        end
        if (sel < 90) begin
            return $urandom_range(1, 3);
        end
        if (sel < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // attractor-sized values most of the time, full range and extremes otherwise
    function automatic t_word pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return t_word'(int'($urandom_range(0, 32'd1610612736)) - 805306368);
        end
        if (sel < 9) begin
            return t_word'($urandom);
        end
        case ($urandom_range(0, 3))
            0: return WORD_TOP;
            1: return WORD_BOT;
            2: return t_word'(0);
            default: return t_word'(-1);
        endcase
    endfunction

    function automatic t_gain pick_gain(int typical_max);
        if ($urandom_range(0, 4) == 0) begin
            return t_gain'($urandom);
        end
        return t_gain'($urandom_range(0, typical_max));
    endfunction

    // output side: check every accepted word, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_output({o_pos_x, o_pos_y, o_pos_z, o_jac_xx, o_jac_xy, o_jac_yx,
                                  o_jac_yy, o_jac_yz, o_jac_zx, o_jac_zy, o_jac_zz});
        end
        if (rx_hold > 0 && !no_gaps) begin
            rx_hold = rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                rx_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without an accepted word", quiet_cycles);
            $display("lorenz_euler_integrator_top verification failed");
            $finish;
        end
    end

    task automatic send_command(t_cmd cmd, t_word lx, t_word ly, t_word lz);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            // idle cycles carry junk on the payload
            i_valid  <= 1'b0;
            i_cmd    <= t_cmd'($urandom);
            i_load_x <= t_word'($urandom);
            i_load_y <= t_word'($urandom);
            i_load_z <= t_word'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_load_x <= lx;
        i_load_y <= ly;
        i_load_z <= lz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_command(cmd, lx, ly, lz);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_gains(t_gain s, t_gain r, t_gain b, t_gain d);
        t_cfg_idx regs [4];
        t_gain vals [4];
        regs = '{CFG_SIGMA, CFG_RHO, CFG_BETA, CFG_DT};
        vals = '{s, r, b, d};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_wen  <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            tracker.set_gain(regs[i], vals[i]);
        end
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        i_cfg_data <= t_gain'($urandom);
        n_settings++;
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            send_command(CMD_STEP, t_word'($urandom), t_word'($urandom), t_word'($urandom));
        end else if (sel < 82) begin
            send_command(CMD_LOAD, pick_coord(), pick_coord(), pick_coord());
        end else if (sel < 94) begin
            send_command(CMD_QUERY, t_word'($urandom), t_word'($urandom), t_word'($urandom));
        end else begin
            send_command(CMD_SPARE, t_word'($urandom), t_word'($urandom), t_word'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset gains
        send_command(CMD_QUERY, 0, 0, 0);
        // unused code acts as a query, load fields ignored
        send_command(CMD_SPARE, WORD_TOP, WORD_BOT, t_word'(-1));
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_STEP, WORD_TOP, WORD_TOP, WORD_TOP);
        send_command(CMD_LOAD, WORD_TOP, WORD_TOP, WORD_TOP);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_LOAD, WORD_BOT, WORD_BOT, WORD_BOT);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_LOAD, WORD_TOP, WORD_BOT, 0);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_LOAD, WORD_BOT, WORD_TOP, WORD_TOP);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_LOAD, 0, 0, 0);
        send_command(CMD_STEP, 0, 0, 0);
        send_command(CMD_LOAD, t_word'(-1), t_word'(-1), t_word'(-1));
        send_command(CMD_QUERY, WORD_BOT, WORD_BOT, WORD_BOT);
        send_command(CMD_LOAD, t_word'(1), t_word'(-1), WORD_BOT);
        send_command(CMD_SPARE, 0, 0, 0);
        send_command(CMD_LOAD, t_word'(1 << 24), t_word'(1 << 24), t_word'(1 << 24));
        send_command(CMD_STEP, 0, 0, 0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle_block();
            case (p)
                0: program_gains(31'd167772160, 31'd469762048, 31'd44739243, 31'd167772);
                1: program_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
                2: program_gains(GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP);
                3: program_gains(GAIN_TOP, GAIN_ZERO, GAIN_TOP, 31'd16777216);
                4: program_gains(GAIN_ZERO, GAIN_TOP, GAIN_ZERO, GAIN_TOP);
                default: program_gains(pick_gain(20 << 24), pick_gain(60 << 24),
                                       pick_gain(6 << 24), pick_gain(1 << 22));
            endcase
            // put the starting point near the attractor for the well-formed runs
            send_command(CMD_LOAD, t_word'(172446292), t_word'(149556801),
                         t_word'(517102318));
            for (int k = 1; k < ITEMS_PER_PHASE; k++) begin
                no_gaps = (k >= 100 && k < 140);
                random_item();
            end
            no_gaps = 1'b0;
        end

        settle_block();
        $display("covered %0d steps, %0d loads, %0d queries and %0d unused-code words",
                 tracker.n_step, tracker.n_load, tracker.n_query, tracker.n_spare);
        $display("over %0d gain settings; %0d output words checked, %0d mismatches",
                 n_settings, tracker.n_seen, tracker.n_bad);
        if (tracker.n_bad == 0 && tracker.pending() == 0) begin
            $display("lorenz_euler_integrator_top verification clean");
        end else begin
            $display("lorenz_euler_integrator_top verification failed");
        end
        $finish;
    end

endmodule
